@@ src/afr_pkg.sv @@
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants of the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned INDEX_W = 2;

   localparam logic [BYTE_W-1:0] CH_COLON = 8'd58;
   localparam logic [BYTE_W-1:0] CH_QUERY = 8'd63;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;

   localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'd0;

   localparam logic [KIND_W-1:0] EV_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] EV_INFO    = 2'd1;
   localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

   localparam logic [INDEX_W-1:0] REG_OWN_ADDR   = 2'd0;
   localparam logic [INDEX_W-1:0] REG_ALT_ADDR   = 2'd1;
   localparam logic [INDEX_W-1:0] REG_ALT_ENABLE = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] own_address;
      logic [BYTE_W-1:0] alt_address;
      logic              alt_address_enable;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_byte;
      logic [BYTE_W-1:0] frame_length;
   } rsp_type;

endpackage

@@ src/afr_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// afr_frame_fsm
// Header hunt with info request detection, address and length decode, and payload pass or skip.
// ----------------------------------------------------------------------------
module afr_frame_fsm #(
   parameter int unsigned MAX_FRAME_LEN = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_accept,
   input  logic [7:0]               in_byte,
   input  afr_pkg::cfg_type         cfg,
   output logic                     res_valid,
   output afr_pkg::rsp_type         res
);
   import afr_pkg::*;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_TAKE = 3'd3;
   localparam logic [2:0] PH_SKIP = 3'd4;

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME_LEN);

   logic [2:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] hist_ff [3];
   logic [BYTE_W-1:0] hist_in [3];
   logic              match_ff, match_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] count_inc, remaining_dec;

   assign count_inc     = count_ff + 8'd1;
   assign remaining_dec = remaining_ff - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      hist_in      = hist_ff;
      match_in     = match_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      res_valid    = 1'b0;
      res          = '0;
      case (phase_ff)
         PH_ADDR: begin
            match_in = (in_byte == cfg.own_address) || (in_byte == BROADCAST_ADDR) ||
                       (cfg.alt_address_enable && (in_byte == cfg.alt_address));
            remaining_in = '0;
            phase_in     = PH_LEN;
         end
         PH_LEN: begin
            if ((in_byte <= 8'd1) || (in_byte > MAX_LEN)) begin
               remaining_in = '0;
               phase_in     = PH_HUNT;
            end else begin
               remaining_in = in_byte;
               count_in     = '0;
               phase_in     = match_ff ? PH_TAKE : PH_SKIP;
            end
         end
         PH_TAKE: begin
            count_in         = count_inc;
            res_valid        = 1'b1;
            res.event_kind   = EV_PAYLOAD;
            res.payload_byte = in_byte;
            res.frame_length = remaining_ff;
            if (count_inc >= remaining_ff) begin
               res.last_byte = 1'b1;
               count_in      = '0;
               remaining_in  = '0;
               phase_in      = PH_HUNT;
            end
         end
         PH_SKIP: begin
            count_in     = count_inc;
            remaining_in = remaining_dec;
            if (remaining_dec == 8'd0) begin
               res_valid        = 1'b1;
               res.event_kind   = EV_RELEASE;
               res.frame_length = count_inc;
               count_in         = '0;
               phase_in         = PH_HUNT;
            end
         end
         default: begin
            phase_in   = PH_HUNT;
            hist_in[0] = hist_ff[1];
            hist_in[1] = hist_ff[2];
            hist_in[2] = in_byte;
            if ((hist_ff[2] == CH_COLON) && (in_byte == CH_COLON)) begin
               hist_in[0] = '0;
               hist_in[1] = '0;
               hist_in[2] = '0;
               phase_in   = PH_ADDR;
            end else if ((hist_ff[1] == CH_QUERY) && (hist_ff[2] == CH_CR) &&
                         (in_byte == CH_LF)) begin
               res_valid      = 1'b1;
               res.event_kind = EV_INFO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         hist_ff[0]   <= '0;
         hist_ff[1]   <= '0;
         hist_ff[2]   <= '0;
         match_ff     <= 1'b0;
         remaining_ff <= '0;
         count_ff     <= '0;
      end else if (in_accept) begin
         phase_ff     <= phase_in;
         hist_ff      <= hist_in;
         match_ff     <= match_in;
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_take_count_below_len : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TAKE) |-> (count_ff < remaining_ff))
      else $error("payload count reached frame length inside a frame");
   a_skip_len_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (remaining_ff != 8'd0))
      else $error("skip phase with nothing left to skip");
   a_payload_only_in_take : assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.event_kind == EV_PAYLOAD)) |-> (phase_ff == PH_TAKE))
      else $error("payload result outside an accepted frame");
   a_len_phase_after_addr : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (($past(phase_ff) == PH_ADDR) ||
                                ($past(phase_ff) == PH_LEN)))
      else $error("length phase not entered from address phase");
`endif

endmodule

@@ src/afr_out_stage.sv @@
// ----------------------------------------------------------------------------
// afr_out_stage
// Result register with a skid entry, decoupling input and result handshakes.
// ----------------------------------------------------------------------------
module afr_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  afr_pkg::rsp_type push_data,
   output logic             in_ready,
   output logic             out_valid,
   output afr_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import afr_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_implies_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while the result register is empty");
   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready && push))
      else $error("skid entry filled without a stalled result");
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while both entries are full");
`endif

endmodule

@@ src/addressed_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// addressed_frame_receiver_unit
// Parses addressed, length-prefixed frames from a received byte stream.
//
//   Channel  Direction  Contents
//   req_     in         one received byte per transaction
//   rsp_     out        payload byte, info request or foreign frame end
//   csr_     in         write of own, alternate address and its enable
//
// A new byte can be taken every cycle while req_tready is high.
// Results leave through a result register backed by one skid entry, so
// req_tready drops only when both hold a result that is not yet taken.
// Reset is synchronous and returns the parser to header hunting.
// Register writes apply from the next address byte onward.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_unit #(
   parameter int unsigned MAX_FRAME_LEN = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [15:8] frame_length
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import afr_pkg::*;

   cfg_type cfg_ff;
   logic    req_accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address        <= 8'd1;
         cfg_ff.alt_address        <= 8'd0;
         cfg_ff.alt_address_enable <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_OWN_ADDR:   cfg_ff.own_address        <= csr_wdata;
            REG_ALT_ADDR:   cfg_ff.alt_address        <= csr_wdata;
            REG_ALT_ENABLE: cfg_ff.alt_address_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_accept = req_tvalid && req_tready;

   afr_frame_fsm #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   afr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && res_valid),
      .push_data (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_data.frame_length, out_data.payload_byte};
   assign rsp_tlast = out_data.last_byte;
   assign rsp_tuser = out_data.event_kind;

endmodule
